FILE: rtl/segint_pkg.sv
`timescale 1ns / 1ps
package segint_pkg;
	// Input coordinate order inside tdata, lowest slot first
	typedef enum logic [2:0] {
		CO_AX = 3'd0,
		CO_AY = 3'd1,
		CO_BX = 3'd2,
		CO_BY = 3'd3,
		CO_CX = 3'd4,
		CO_CY = 3'd5,
		CO_DX = 3'd6,
		CO_DY = 3'd7
	} coord_idx_t;

	localparam int unsigned NUM_COORDS = 8;
endpackage

FILE: rtl/segment_intersection_int.sv
`timescale 1ns / 1ps
// Channel   | Direction | tdata (low bit up)          | tuser | tlast
// ----------+-----------+-----------------------------+-------+------
// s_axis    | in        | ax, ay, bx, by, cx, cy, dx, dy | -  | -
// m_axis    | out       | px, py, zero pad to bytes    | hit   | -
//
// Cycles: one request enters every cycle while m_axis is not stalled; the pipe is
// five arithmetic stages, COORD_WIDTH + 1 restoring divide stages and one
// output register. The divide chain produces one quotient bit per stage.
// Reset: arst_n clears the valid bits of every stage; data registers are not reset.
// Stalls: the whole pipe holds while a result waits on m_axis_tready low;
// s_axis_tready drops in the same cycle, so nothing is lost or repeated.
module segment_intersection_int
	import segint_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// ax, ay, bx, by, cx, cy, dx, dy, COORD_WIDTH bits each
	input  logic [NUM_COORDS*COORD_WIDTH-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// px, py, then zero pad
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
	// hit
	output logic                                 m_axis_tuser
);
	localparam int W   = COORD_WIDTH;
	localparam int AW  = W + 1;          // line coefficient a, b
	localparam int CW  = 2*W + 1;        // line constant c
	localparam int PW  = 2*W + 2;        // coefficient products
	localparam int SW  = 2*W + 3;        // side values, denominator
	localparam int NW  = 3*W + 4;        // numerators and divide remainder
	localparam int QW  = W + 1;          // quotient bits kept
	localparam int OW  = ((2*W+7)/8)*8;

	// Advance the whole pipe unless a result is stuck at the output
	logic adv;
	logic out_vld_q;
	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;

	logic signed [W-1:0] co [NUM_COORDS];
	always_comb begin
		for (int k = 0; k < NUM_COORDS; k++) begin
			co[k] = s_axis_tdata[k*W +: W];
		end
	end

	// ---------------- Stage 1: coefficients, cross products for c ----------------
	logic                  vld_s1;
	logic signed [W-1:0]   co_s1 [NUM_COORDS];
	logic signed [AW-1:0]  a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [2*W-1:0] x2y1_s1, x1y2_s1, x4y3_s1, x3y4_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_COORDS; k++) co_s1[k] <= co[k];
			a1_s1   <= AW'(co[CO_BY]) - AW'(co[CO_AY]);
			b1_s1   <= AW'(co[CO_AX]) - AW'(co[CO_BX]);
			a2_s1   <= AW'(co[CO_DY]) - AW'(co[CO_CY]);
			b2_s1   <= AW'(co[CO_CX]) - AW'(co[CO_DX]);
			x2y1_s1 <= (2*W)'(co[CO_BX]) * (2*W)'(co[CO_AY]);
			x1y2_s1 <= (2*W)'(co[CO_AX]) * (2*W)'(co[CO_BY]);
			x4y3_s1 <= (2*W)'(co[CO_DX]) * (2*W)'(co[CO_CY]);
			x3y4_s1 <= (2*W)'(co[CO_CX]) * (2*W)'(co[CO_DY]);
		end
	end

	// ---------------- Stage 2: c terms, denominator products and side products ----------------
	logic                  vld_s2;
	logic signed [AW-1:0]  a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [CW-1:0]  c1_s2, c2_s2;
	logic signed [PW-1:0]  d1_s2, d2_s2;
	logic signed [CW-1:0]  sp_s2 [8];

	always_ff @(posedge clk) begin
		if (adv) begin
			a1_s2 <= a1_s1;
			b1_s2 <= b1_s1;
			a2_s2 <= a2_s1;
			b2_s2 <= b2_s1;
			c1_s2 <= CW'(x2y1_s1) - CW'(x1y2_s1);
			c2_s2 <= CW'(x4y3_s1) - CW'(x3y4_s1);
			d1_s2 <= PW'(a1_s1) * PW'(b2_s1);
			d2_s2 <= PW'(a2_s1) * PW'(b1_s1);
			// line 1 at C and D, line 2 at A and B
			sp_s2[0] <= CW'(a1_s1) * CW'(co_s1[CO_CX]);
			sp_s2[1] <= CW'(b1_s1) * CW'(co_s1[CO_CY]);
			sp_s2[2] <= CW'(a1_s1) * CW'(co_s1[CO_DX]);
			sp_s2[3] <= CW'(b1_s1) * CW'(co_s1[CO_DY]);
			sp_s2[4] <= CW'(a2_s1) * CW'(co_s1[CO_AX]);
			sp_s2[5] <= CW'(b2_s1) * CW'(co_s1[CO_AY]);
			sp_s2[6] <= CW'(a2_s1) * CW'(co_s1[CO_BX]);
			sp_s2[7] <= CW'(b2_s1) * CW'(co_s1[CO_BY]);
		end
	end

	// ---------------- Stage 3: side sums, denominator, numerator partials ----------------
	// c is split into an unsigned low half and a signed high half so every
	// product stays near COORD_WIDTH by COORD_WIDTH
	logic                  vld_s3;
	logic signed [SW-1:0]  den_s3;
	logic signed [SW-1:0]  sv_s3 [4];
	logic signed [PW-1:0]  np_lo_s3 [4];
	logic signed [PW-1:0]  np_hi_s3 [4];

	logic signed [AW-1:0]  c1_lo, c2_lo, c1_hi, c2_hi;
	assign c1_lo = $signed({1'b0, c1_s2[W-1:0]});
	assign c2_lo = $signed({1'b0, c2_s2[W-1:0]});
	assign c1_hi = c1_s2[CW-1:W];
	assign c2_hi = c2_s2[CW-1:W];

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s3   <= SW'(d1_s2) - SW'(d2_s2);
			sv_s3[0] <= SW'(sp_s2[0]) + SW'(sp_s2[1]) + SW'(c1_s2);
			sv_s3[1] <= SW'(sp_s2[2]) + SW'(sp_s2[3]) + SW'(c1_s2);
			sv_s3[2] <= SW'(sp_s2[4]) + SW'(sp_s2[5]) + SW'(c2_s2);
			sv_s3[3] <= SW'(sp_s2[6]) + SW'(sp_s2[7]) + SW'(c2_s2);
			// x: b1*c2 - b2*c1, y: a2*c1 - a1*c2
			np_lo_s3[0] <= PW'(b1_s2) * PW'(c2_lo);
			np_hi_s3[0] <= PW'(b1_s2) * PW'(c2_hi);
			np_lo_s3[1] <= PW'(b2_s2) * PW'(c1_lo);
			np_hi_s3[1] <= PW'(b2_s2) * PW'(c1_hi);
			np_lo_s3[2] <= PW'(a2_s2) * PW'(c1_lo);
			np_hi_s3[2] <= PW'(a2_s2) * PW'(c1_hi);
			np_lo_s3[3] <= PW'(a1_s2) * PW'(c2_lo);
			np_hi_s3[3] <= PW'(a1_s2) * PW'(c2_hi);
		end
	end

	// ---------------- Stage 4: side tests and full numerators ----------------
	logic                 vld_s4;
	logic                 hit_s4;
	logic signed [SW-1:0] den_s4;
	logic signed [NW-1:0] nx_s4, ny_s4;

	logic same1, same2;
	logic signed [NW-1:0] term [4];
	assign same1 = (sv_s3[0] != '0) && (sv_s3[1] != '0) &&
		(sv_s3[0][SW-1] == sv_s3[1][SW-1]);
	assign same2 = (sv_s3[2] != '0) && (sv_s3[3] != '0) &&
		(sv_s3[2][SW-1] == sv_s3[3][SW-1]);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			term[k] = (NW'(np_hi_s3[k]) <<< W) + NW'(np_lo_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s4 <= !same1 && !same2 && (den_s3 != '0);
			den_s4 <= den_s3;
			nx_s4  <= term[0] - term[1];
			ny_s4  <= term[2] - term[3];
		end
	end

	// ---------------- Stage 5: rounding offset, magnitudes, signs ----------------
	logic                 vld_s5;
	logic                 hit_s5, negx_s5, negy_s5;
	logic [NW-1:0]        unx_s5, uny_s5, ud_s5;

	logic [SW-1:0]        den_mag, off;
	logic signed [NW-1:0] adjx, adjy;
	assign den_mag = den_s4[SW-1] ? SW'(-den_s4) : SW'(den_s4);
	assign off     = den_mag >> 1;
	assign adjx    = nx_s4[NW-1] ? nx_s4 - NW'(off) : nx_s4 + NW'(off);
	assign adjy    = ny_s4[NW-1] ? ny_s4 - NW'(off) : ny_s4 + NW'(off);

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s5  <= hit_s4;
			negx_s5 <= adjx[NW-1] ^ den_s4[SW-1];
			negy_s5 <= adjy[NW-1] ^ den_s4[SW-1];
			unx_s5  <= adjx[NW-1] ? NW'(-adjx) : NW'(adjx);
			uny_s5  <= adjy[NW-1] ? NW'(-adjy) : NW'(adjy);
			ud_s5   <= NW'(den_mag);
		end
	end

	// ---------------- Divide stages: one quotient bit each, high bit first ----------------
	logic          vld_sd  [QW+1];
	logic          hit_sd  [QW+1];
	logic          negx_sd [QW+1];
	logic          negy_sd [QW+1];
	logic [NW-1:0] remx_sd [QW+1];
	logic [NW-1:0] remy_sd [QW+1];
	logic [NW-1:0] ud_sd   [QW+1];
	logic [QW-1:0] qx_sd   [QW+1];
	logic [QW-1:0] qy_sd   [QW+1];

	assign vld_sd[0]  = vld_s5;
	assign hit_sd[0]  = hit_s5;
	assign negx_sd[0] = negx_s5;
	assign negy_sd[0] = negy_s5;
	assign remx_sd[0] = unx_s5;
	assign remy_sd[0] = uny_s5;
	assign ud_sd[0]   = ud_s5;
	assign qx_sd[0]   = '0;
	assign qy_sd[0]   = '0;

	for (genvar g = 0; g < QW; g++) begin : g_div
		localparam int SH = QW - 1 - g;
		logic [NW:0] trx, try_v;
		assign trx   = {1'b0, remx_sd[g]} - {1'b0, ud_sd[g] << SH};
		assign try_v = {1'b0, remy_sd[g]} - {1'b0, ud_sd[g] << SH};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[g+1] <= 1'b0;
			end else if (adv) begin
				vld_sd[g+1] <= vld_sd[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				hit_sd[g+1]  <= hit_sd[g];
				negx_sd[g+1] <= negx_sd[g];
				negy_sd[g+1] <= negy_sd[g];
				ud_sd[g+1]   <= ud_sd[g];
				remx_sd[g+1] <= trx[NW] ? remx_sd[g] : trx[NW-1:0];
				remy_sd[g+1] <= try_v[NW] ? remy_sd[g] : try_v[NW-1:0];
				qx_sd[g+1]   <= qx_sd[g] | (QW'(!trx[NW]) << SH);
				qy_sd[g+1]   <= qy_sd[g] | (QW'(!try_v[NW]) << SH);
			end
		end
	end

	// ---------------- Output register ----------------
	logic          hit_q;
	logic [W-1:0]  px_q, py_q;
	logic [QW-1:0] qx_fin, qy_fin;
	assign qx_fin = negx_sd[QW] ? QW'(-qx_sd[QW]) : qx_sd[QW];
	assign qy_fin = negy_sd[QW] ? QW'(-qy_sd[QW]) : qy_sd[QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			out_vld_q <= vld_sd[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= hit_sd[QW];
			// zero the point on a miss
			px_q  <= hit_sd[QW] ? qx_fin[W-1:0] : '0;
			py_q  <= hit_sd[QW] ? qy_fin[W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = hit_q;
	assign m_axis_tdata  = OW'({py_q, px_q});

	// ---------------- Assertions ----------------
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (px_q == '0) && (py_q == '0))
		else $error("point not zero on a miss");

	a_par_miss: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && (den_s4 == '0) |-> !hit_s4)
		else $error("hit on zero denominator");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tvalid && !m_axis_tready) |-> $stable(hit_q) && $stable(px_q))
		else $error("stalled result changed");
endmodule
